// ----- sv/itt_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Identity track table package
// Shared types and constants for the track table: transaction payloads, the
// stored entry layout, scan flags, outcome codes and controller states.
// ----------------------------------------------------------------------------
package itt_pkg;

    localparam int unsigned ID_FIELD_BYTES = 20;
    localparam int unsigned ID_W           = 8 * ID_FIELD_BYTES;
    localparam logic [31:0] TTL_RESET      = 32'd60000;

    typedef struct packed {
        logic [47:0] mac;
        logic [63:0] id_head;
        logic [63:0] id_middle;
        logic [31:0] id_tail;
        logic [31:0] now_ms;
    } itt_sighting_t;

    typedef struct packed {
        logic [3:0]  slot;
        logic [2:0]  outcome;
        logic [4:0]  expired_count;
        logic        id_known;
        logic [63:0] track_id_head;
        logic [63:0] track_id_middle;
        logic [31:0] track_id_tail;
    } itt_result_t;

    typedef struct packed {
        logic [31:0] ttl_ms;
    } itt_cfg_t;

    // One stored track; the used bit lives in flip-flops outside the memory.
    typedef struct packed {
        logic [47:0]     address;
        logic [31:0]     last_seen;
        logic [ID_W-1:0] id;
    } itt_entry_t;

    typedef struct packed {
        logic expired;
        logic addr_eq;
        logic id_eq;
        logic has_id;
        logic older;
    } itt_scan_flags_t;

    typedef enum logic [2:0] {
        OUT_ID_MATCH   = 3'd0,
        OUT_ADOPTED    = 3'd1,
        OUT_ADDR_MATCH = 3'd2,
        OUT_FREE_SLOT  = 3'd3,
        OUT_EVICTED    = 3'd4
    } itt_outcome_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE
    } itt_state_t;

endpackage

`default_nettype wire

// ----- sv/itt_stream_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Valid/ready stream interface
// One channel carrying a typed payload; a transaction completes on a rising
// clock edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface itt_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- sv/identity_track_table_core.sv -----
`default_nettype none
// A sighting is accepted only in the idle state, so the next one waits until
// the previous one has been decided; the entry memory's single read port is
// walked one entry per cycle through the shared scan unit.
// Reset clears every used bit and loads the lifetime with 60000 ms; the entry
// memory needs no clearing pass, so a sighting is accepted right after reset.
// ----------------------------------------------------------------------------
// Identity track table core
// Expires silent tracks, finds or allocates a track for each sighting, updates
// it and reports the slot, the outcome, the expiry count and the identity.
// ----------------------------------------------------------------------------
module identity_track_table_core #(
    parameter int unsigned TRACKS   = 16,
    parameter int unsigned ID_BYTES = 20
) (
    input wire logic   clk,
    input wire logic   rst_n,
    itt_stream_if.sink   sighting,
    itt_stream_if.source result,
    itt_stream_if.sink   cfg
);
    import itt_pkg::*;

    localparam int unsigned IDX_W = $clog2(TRACKS);
    localparam int unsigned CNT_W = $clog2(TRACKS + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TRACKS - 1);

    // The identity ends at its first zero byte and at ID_BYTES.
    function automatic logic [ID_W-1:0] normalize_id(input logic [ID_W-1:0] raw);
        logic            alive;
        logic [7:0]      b;
        logic [ID_W-1:0] res;
        alive = 1'b1;
        res   = '0;
        for (int k = 0; k < ID_FIELD_BYTES; k++)
        begin
            b = raw[ID_W-1-8*k -: 8];
            if (k >= ID_BYTES || b == 8'h00)
            begin
                alive = 1'b0;
            end
            if (alive)
            begin
                res[ID_W-1-8*k -: 8] = b;
            end
        end
        return res;
    endfunction

    itt_state_t state_reg, state_next;
    logic [IDX_W-1:0] scan_idx_reg, scan_idx_next;
    logic             eval_valid_reg;
    logic [IDX_W-1:0] eval_idx_reg;

    logic [31:0]      ttl_reg;
    logic [TRACKS-1:0] used_reg;
    logic [CNT_W-1:0] expired_cnt_reg;

    logic [47:0]      sig_mac_reg;
    logic [ID_W-1:0]  sig_id_reg;
    logic             sig_have_id_reg;
    logic [31:0]      sig_now_reg;

    logic             id_hit_reg, adopt_hit_reg, addr_hit_reg, free_hit_reg;
    logic [IDX_W-1:0] id_idx_reg, adopt_idx_reg, addr_idx_reg, free_idx_reg;
    logic [ID_W-1:0]  addr_id_reg;
    logic [IDX_W-1:0] oldest_idx_reg;
    logic [31:0]      oldest_ts_reg;

    logic             result_valid_reg;
    itt_result_t      result_payload_reg;

    logic             in_ready;
    logic             rd_en;
    logic             decide_go;
    logic             sighting_fire;
    logic [ID_W-1:0]  in_id_norm;

    itt_entry_t       rd_entry;
    itt_entry_t       wr_entry;
    itt_scan_flags_t  flags;
    logic             used_now;
    logic             live_now;

    logic             alloc;
    logic [IDX_W-1:0] pick_idx;
    itt_outcome_t     pick_outcome;
    logic [ID_W-1:0]  write_id;
    logic [IDX_W+3:0] pick_ext;
    logic [CNT_W+4:0] cnt_ext;

    // ------------------------------------------------------------------
    // Channels
    // ------------------------------------------------------------------
    assign sighting.ready = in_ready;
    assign sighting_fire  = sighting.valid && in_ready;
    assign cfg.ready      = 1'b1;
    assign result.valid   = result_valid_reg;
    assign result.payload = result_payload_reg;

    assign in_id_norm = normalize_id({sighting.payload.id_head, sighting.payload.id_middle,
                                      sighting.payload.id_tail});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ttl_reg <= TTL_RESET;
        end
        else if (cfg.valid)
        begin
            ttl_reg <= cfg.payload.ttl_ms;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sighting_fire)
        begin
            sig_mac_reg     <= sighting.payload.mac;
            sig_id_reg      <= in_id_norm;
            sig_have_id_reg <= in_id_norm[ID_W-1 -: 8] != 8'h00;
            sig_now_reg     <= sighting.payload.now_ms;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next    = state_reg;
        scan_idx_next = scan_idx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                scan_idx_next = '0;
                if (sighting.valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                scan_idx_next = scan_idx_reg + 1'b1;
                if (scan_idx_reg == LAST_IDX)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (decide_go)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready  = 1'b0;
        rd_en     = 1'b0;
        decide_go = 1'b0;
        unique case (state_reg)
            ST_IDLE:   in_ready = 1'b1;
            ST_SCAN:   rd_en = 1'b1;
            ST_DRAIN:  ;
            ST_DECIDE: decide_go = !result_valid_reg || result.ready;
            default:   ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            scan_idx_reg   <= '0;
            eval_valid_reg <= 1'b0;
            eval_idx_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            scan_idx_reg   <= scan_idx_next;
            eval_valid_reg <= rd_en;
            eval_idx_reg   <= scan_idx_reg;
        end
    end

    // ------------------------------------------------------------------
    // Entry memory and the shared scan unit
    // ------------------------------------------------------------------
    itt_entry_ram #(
        .DEPTH (TRACKS),
        .AW    (IDX_W)
    ) u_ram (
        .clk   (clk),
        .we    (decide_go),
        .waddr (pick_idx),
        .wdata (wr_entry),
        .re    (rd_en),
        .raddr (scan_idx_reg),
        .rdata (rd_entry)
    );

    itt_scan_unit u_scan (
        .entry     (rd_entry),
        .mac       (sig_mac_reg),
        .id        (sig_id_reg),
        .now_ms    (sig_now_reg),
        .ttl_ms    (ttl_reg),
        .oldest_ts (oldest_ts_reg),
        .flags     (flags)
    );

    assign used_now = used_reg[eval_idx_reg];
    assign live_now = used_now && !flags.expired;

    // Candidates are sticky on the first hit, so the lowest index wins.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg        <= '0;
            expired_cnt_reg <= '0;
            id_hit_reg      <= 1'b0;
            adopt_hit_reg   <= 1'b0;
            addr_hit_reg    <= 1'b0;
            free_hit_reg    <= 1'b0;
        end
        else if (sighting_fire)
        begin
            expired_cnt_reg <= '0;
            id_hit_reg      <= 1'b0;
            adopt_hit_reg   <= 1'b0;
            addr_hit_reg    <= 1'b0;
            free_hit_reg    <= 1'b0;
        end
        else if (eval_valid_reg)
        begin
            if (used_now && flags.expired)
            begin
                used_reg[eval_idx_reg] <= 1'b0;
                expired_cnt_reg        <= expired_cnt_reg + 1'b1;
            end
            if (!id_hit_reg && live_now && flags.has_id && flags.id_eq)
            begin
                id_hit_reg <= 1'b1;
            end
            if (!adopt_hit_reg && live_now && !flags.has_id && flags.addr_eq)
            begin
                adopt_hit_reg <= 1'b1;
            end
            if (!addr_hit_reg && live_now && flags.addr_eq)
            begin
                addr_hit_reg <= 1'b1;
            end
            if (!free_hit_reg && !live_now)
            begin
                free_hit_reg <= 1'b1;
            end
        end
        else if (decide_go)
        begin
            used_reg[pick_idx] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (eval_valid_reg)
        begin
            if (!id_hit_reg)
            begin
                id_idx_reg <= eval_idx_reg;
            end
            if (!adopt_hit_reg)
            begin
                adopt_idx_reg <= eval_idx_reg;
            end
            if (!addr_hit_reg)
            begin
                addr_idx_reg <= eval_idx_reg;
                addr_id_reg  <= rd_entry.id;
            end
            if (!free_hit_reg)
            begin
                free_idx_reg <= eval_idx_reg;
            end
            if (eval_idx_reg == '0 || flags.older)
            begin
                oldest_idx_reg <= eval_idx_reg;
                oldest_ts_reg  <= rd_entry.last_seen;
            end
        end
    end

    // ------------------------------------------------------------------
    // Track choice and update
    // ------------------------------------------------------------------
    always_comb
    begin
        alloc        = 1'b0;
        pick_idx     = oldest_idx_reg;
        pick_outcome = OUT_EVICTED;
        priority if (sig_have_id_reg && id_hit_reg)
        begin
            pick_idx     = id_idx_reg;
            pick_outcome = OUT_ID_MATCH;
        end
        else if (sig_have_id_reg && adopt_hit_reg)
        begin
            pick_idx     = adopt_idx_reg;
            pick_outcome = OUT_ADOPTED;
        end
        else if (!sig_have_id_reg && addr_hit_reg)
        begin
            pick_idx     = addr_idx_reg;
            pick_outcome = OUT_ADDR_MATCH;
        end
        else if (free_hit_reg)
        begin
            alloc        = 1'b1;
            pick_idx     = free_idx_reg;
            pick_outcome = OUT_FREE_SLOT;
        end
        else
        begin
            alloc        = 1'b1;
            pick_idx     = oldest_idx_reg;
            pick_outcome = OUT_EVICTED;
        end
    end

    // A new or evicted track starts without identity unless one came in.
    assign write_id = sig_have_id_reg ? sig_id_reg : (alloc ? '0 : addr_id_reg);

    assign wr_entry.address   = sig_mac_reg;
    assign wr_entry.last_seen = sig_now_reg;
    assign wr_entry.id        = write_id;

    assign pick_ext = {4'b0000, pick_idx};
    assign cnt_ext  = {5'b00000, expired_cnt_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (decide_go)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (decide_go)
        begin
            result_payload_reg.slot            <= pick_ext[3:0];
            result_payload_reg.outcome         <= pick_outcome;
            result_payload_reg.expired_count   <= cnt_ext[4:0];
            result_payload_reg.id_known        <= write_id[ID_W-1 -: 8] != 8'h00;
            result_payload_reg.track_id_head   <= write_id[ID_W-1 -: 64];
            result_payload_reg.track_id_middle <= write_id[ID_W-65 -: 64];
            result_payload_reg.track_id_tail   <= write_id[31:0];
        end
    end

`ifndef SYNTHESIS
    a_result_from_decide: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(state_reg == ST_DECIDE))
        else $error("result raised outside the decide step");

    a_free_slot_unused: assert property (@(posedge clk) disable iff (!rst_n)
        (decide_go && pick_outcome == OUT_FREE_SLOT) |-> !used_reg[pick_idx])
        else $error("free slot chosen while still in use");

    a_pick_marked_used: assert property (@(posedge clk) disable iff (!rst_n)
        decide_go |=> used_reg[$past(pick_idx)])
        else $error("chosen track not marked used after update");

    a_no_read_while_idle: assert property (@(posedge clk) disable iff (!rst_n)
        sighting_fire |=> !eval_valid_reg)
        else $error("scan data pending when a sighting was accepted");
`endif

endmodule

`default_nettype wire

// ----- sv/itt_entry_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Track entry memory
// Single write port and one registered read port holding the address, the
// last-seen time and the identity of every track.
// ----------------------------------------------------------------------------
module itt_entry_ram #(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned AW    = 4
) (
    input  wire logic                clk,
    input  wire logic                we,
    input  wire logic [AW-1:0]       waddr,
    input  wire itt_pkg::itt_entry_t wdata,
    input  wire logic                re,
    input  wire logic [AW-1:0]       raddr,
    output      itt_pkg::itt_entry_t rdata
);
    import itt_pkg::*;

    itt_entry_t mem [DEPTH];
    itt_entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- sv/itt_scan_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Track scan unit
// Shared compare unit applied to one stored entry per cycle: lifetime check,
// address and identity match, and the last-seen comparison for eviction.
// ----------------------------------------------------------------------------
module itt_scan_unit (
    input  wire itt_pkg::itt_entry_t   entry,
    input  wire logic [47:0]           mac,
    input  wire logic [itt_pkg::ID_W-1:0] id,
    input  wire logic [31:0]           now_ms,
    input  wire logic [31:0]           ttl_ms,
    input  wire logic [31:0]           oldest_ts,
    output      itt_pkg::itt_scan_flags_t flags
);
    import itt_pkg::*;

    logic [31:0] silence;

    // Silence wraps modulo 2^32 just like the timestamp.
    assign silence = now_ms - entry.last_seen;

    always_comb
    begin
        flags.expired = silence > ttl_ms;
        flags.addr_eq = entry.address == mac;
        flags.id_eq   = entry.id == id;
        flags.has_id  = entry.id[ID_W-1 -: 8] != 8'h00;
        flags.older   = entry.last_seen < oldest_ts;
    end

endmodule

`default_nettype wire
